>>> hdl/fsig_pkg.sv
package fsig_pkg;

    localparam int TRACK_W    = 8;
    localparam int SPT_W      = 5;
    localparam int HEADS_W    = 2;
    localparam int SECTOR_W   = 5;
    localparam int SIZE_W     = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [SPT_W-1:0]   MAX_SECTORS = 5'd31;
    localparam logic [HEADS_W-1:0] MAX_HEADS   = 2'd2;
    localparam logic [SPT_W-1:0]   SPT_RESET   = 5'd18;
    localparam logic [HEADS_W-1:0] HEADS_RESET = 2'd2;
    localparam logic [SIZE_W-1:0]  SIZE_CODE   = 3'd2;
    localparam logic [SPT_W:0]     HEAD_SKEW   = 6'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SPT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADS = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [TRACK_W-1:0] track;
        logic [SPT_W-1:0]   spt;
        logic [HEADS_W-1:0] heads;
    } t_cmd;

endpackage

>>> hdl/fsig_front.sv
module fsig_front import fsig_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TRACK_W-1:0]    i_track_number,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [SPT_W-1:0]   r_spt;
    logic [HEADS_W-1:0] r_heads;
    logic [SPT_W-1:0]   n_spt;
    logic [HEADS_W-1:0] n_heads;
    logic               n_runnable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spt   <= SPT_RESET;
            r_heads <= HEADS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPT:   r_spt   <= i_cfg_data[SPT_W-1:0];
                REG_HEADS: r_heads <= i_cfg_data[HEADS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_spt      = (r_spt > MAX_SECTORS) ? MAX_SECTORS : r_spt;
        n_heads    = (r_heads > MAX_HEADS) ? MAX_HEADS : r_heads;
        n_runnable = (n_spt != '0) && (n_heads != '0);
    end

    // A request with no sectors or no heads is taken and dropped.
    assign o_in_stall  = i_q_full;
    assign o_push      = i_in_valid && !i_q_full && n_runnable;
    assign o_cmd.track = i_track_number;
    assign o_cmd.spt   = n_spt;
    assign o_cmd.heads = n_heads;

endmodule

>>> hdl/fsig_queue.sv
module fsig_queue import fsig_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              n_push;
    logic              n_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && o_valid;
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (n_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({n_push, n_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> hdl/fsig_back.sv
module fsig_back import fsig_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_cmd                i_q_cmd,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TRACK_W-1:0]  o_id_track,
    output logic                o_id_head,
    output logic [SECTOR_W-1:0] o_id_sector,
    output logic                o_last_record
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state              r_state;
    logic [TRACK_W-1:0]  r_track;
    logic [SPT_W-1:0]    r_spt;
    logic [HEADS_W-1:0]  r_heads;
    logic [SPT_W-1:0]    r_split;
    logic [SPT_W-1:0]    r_half;
    logic [SPT_W-1:0]    r_slot;
    logic                r_head;
    logic                r_out_valid;
    logic [TRACK_W-1:0]  r_id_track;
    logic                r_id_head;
    logic [SECTOR_W-1:0] r_id_sector;
    logic                r_last_record;

    logic [SPT_W:0]      n_base;
    logic [SPT_W:0]      n_head_id;
    logic [SPT_W:0]      n_track_id;
    logic                n_slot_last;
    logic                n_head_last;
    logic                n_last;
    logic                n_emit;

    always_comb begin
        n_base = {2'b00, r_slot[SPT_W-1:1]} + (SPT_W+1)'(1);
        if (r_slot[0]) begin
            n_base = n_base + {1'b0, r_split};
        end
        if (!r_head) begin
            n_head_id = n_base;
        end else if (n_base <= HEAD_SKEW) begin
            n_head_id = n_base + {1'b0, r_spt} - HEAD_SKEW;
        end else begin
            n_head_id = n_base - HEAD_SKEW;
        end
        if (!r_track[0]) begin
            n_track_id = n_head_id;
        end else if (n_head_id <= {1'b0, r_half}) begin
            n_track_id = n_head_id + {1'b0, r_spt} - {1'b0, r_half};
        end else begin
            n_track_id = n_head_id - {1'b0, r_half};
        end
        n_slot_last = (r_slot == r_spt - SPT_W'(1));
        n_head_last = ({1'b0, r_head} == r_heads - HEADS_W'(1));
        n_last      = n_slot_last && n_head_last;
        n_emit      = (r_state == S_RUN) && (!r_out_valid || !i_out_stall);
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_slot      <= '0;
            r_head      <= 1'b0;
        end else begin
            if (n_emit) begin
                r_out_valid   <= 1'b1;
                r_id_track    <= r_track;
                r_id_head     <= r_head;
                r_id_sector   <= n_track_id[SECTOR_W-1:0];
                r_last_record <= n_last;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_RUN;
                        r_track <= i_q_cmd.track;
                        r_spt   <= i_q_cmd.spt;
                        r_heads <= i_q_cmd.heads;
                        r_split <= (i_q_cmd.spt >> 1) + SPT_W'(i_q_cmd.spt[0]);
                        r_half  <= i_q_cmd.spt >> 1;
                        r_slot  <= '0;
                        r_head  <= 1'b0;
                    end
                end
                S_RUN: begin
                    if (n_emit) begin
                        if (n_last) begin
                            r_state <= S_IDLE;
                            r_slot  <= '0;
                            r_head  <= 1'b0;
                        end else if (n_slot_last) begin
                            r_slot <= '0;
                            r_head <= 1'b1;
                        end else begin
                            r_slot <= r_slot + SPT_W'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_id_track    = r_id_track;
    assign o_id_head     = r_id_head;
    assign o_id_sector   = r_id_sector;
    assign o_last_record = r_last_record;

    a_run_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_spt != '0) && (r_slot < r_spt)
                               && ({1'b0, r_head} < r_heads))
        else $error("sequencer position outside the current run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_emit && n_last) |=> (r_state == S_IDLE) && r_out_valid && r_last_record)
        else $error("last word did not end the run");

    a_mid_run_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last_record) |-> (r_state == S_RUN))
        else $error("sequencer went idle before the last word");

endmodule

>>> hdl/floppy_format_sector_id_generator_core.sv
// Sector ID generator for track formatting.
// A request word on the input channel carries a track number. For that track
// the block emits one sector ID word per sector slot, head 0 first, then head 1
// when two heads are configured. Each word holds track, head, the interleaved
// and skewed sector number, size code 2, and a flag on the final word.
// Both channels move a word when valid is high and stall is low.
// The configuration port writes the sectors per track and the head count; the
// user must write it only while the block is idle; the block does not enforce this.
// A request enters a two-entry queue in the cycle it is accepted. The idle
// sequencer pops it into its run registers, then registers one ID word per
// cycle into the output register while the receiver does not stall; the
// sequencer that steps slot and head sets this rate.
// A request with zero sectors or zero heads is accepted and gives no words.
// When the receiver stalls, the output word holds and the sequencer waits;
// the input keeps taking requests until the queue is full.
// Reset empties the queue, idles the sequencer, and loads 18 sectors and two
// heads into the configuration.
module floppy_format_sector_id_generator_core import fsig_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TRACK_W-1:0]    i_track_number,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [TRACK_W-1:0]    o_id_track,
    output logic                  o_id_head,
    output logic [SECTOR_W-1:0]   o_id_sector,
    output logic [SIZE_W-1:0]     o_id_size_code,
    output logic                  o_last_record
);

    logic q_full;
    logic q_push;
    t_cmd q_in_cmd;
    logic q_valid;
    t_cmd q_out_cmd;
    logic q_pop;

    fsig_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_track_number (i_track_number),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_cmd          (q_in_cmd)
    );

    fsig_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    fsig_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_id_track    (o_id_track),
        .o_id_head     (o_id_head),
        .o_id_sector   (o_id_sector),
        .o_last_record (o_last_record)
    );

    assign o_id_size_code = SIZE_CODE;

endmodule
